// ===== sv/rrq_pkg.sv =====
// shared types and constants for the rectangle rotate-to-quad pipeline
package rrq_pkg;

    // cordic sizing: 30 steps, 30 fraction bits, two guard bits above the integer bit
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_W     = 34;

    // inverse cordic gain at 30 fraction bits, used as the start vector x
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    // sine/cosine latency: reduction register, one register per step, rounding register
    localparam int SINCOS_LAT = CORDIC_STEPS + 2;

    typedef logic [31:0] atan_t;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam atan_t ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // quadrant of the angle after centering each quadrant on its axis
    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

endpackage

// ===== sv/rrq_sincos.sv =====
// pipelined cordic sine/cosine with quadrant reduction and rounding
module rrq_sincos #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [ANGLE_BITS-1:0]            angle,
    output logic                             out_valid,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_out,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_out
);
    import rrq_pkg::*;

    localparam int TW     = TRIG_FRAC_BITS + 2;
    localparam int RND_SH = CORDIC_FRAC - TRIG_FRAC_BITS;
    localparam logic signed [CORDIC_W:0] RND_HALF =
        (CORDIC_W+1)'(64'sd1 <<< (RND_SH - 1));
    localparam logic signed [CORDIC_W:0] ONE_WIDE =
        (CORDIC_W+1)'(64'sd1 <<< TRIG_FRAC_BITS);
    localparam logic signed [TW-1:0] TRIG_ONE = TW'(64'sd1 <<< TRIG_FRAC_BITS);
    localparam logic signed [CORDIC_W-1:0] Z_TOL = CORDIC_W'(64);

    logic [31:0] angle_full;
    logic [31:0] angle_bias;
    logic [31:0] resid;
    quad_t       quad_in;

    logic                       valid_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] x_reg     [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg     [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_reg     [0:CORDIC_STEPS];
    quad_t                      quad_reg  [0:CORDIC_STEPS];

    logic signed [CORDIC_W:0] x_round;
    logic signed [CORDIC_W:0] y_round;
    logic signed [TW-1:0]     c_clamp;
    logic signed [TW-1:0]     s_clamp;
    logic signed [TW-1:0]     sin_next;
    logic signed [TW-1:0]     cos_next;
    logic signed [TW-1:0]     sin_reg;
    logic signed [TW-1:0]     cos_reg;
    logic                     out_valid_reg;

    // reduce the angle to a quadrant and a residual in [-1/8, 1/8) turn
    assign angle_full = 32'(angle) << (32 - ANGLE_BITS);
    assign angle_bias = angle_full + 32'h2000_0000;
    assign quad_in    = quad_t'(angle_bias[31:30]);
    assign resid      = angle_full - {quad_in, 30'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= CORDIC_W'(signed'(resid));
            quad_reg[0] <= quad_in;
        end
    end

    // one cordic micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic signed [CORDIC_W-1:0] atan_val;
        logic signed [CORDIC_W-1:0] x_next;
        logic signed [CORDIC_W-1:0] y_next;
        logic signed [CORDIC_W-1:0] z_next;

        assign xs       = x_reg[i] >>> i;
        assign ys       = y_reg[i] >>> i;
        assign atan_val = signed'(CORDIC_W'(ATAN_TURNS[i]));

        always_comb begin
            if (!z_reg[i][CORDIC_W-1]) begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - atan_val;
            end else begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + atan_val;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                quad_reg[i+1] <= quad_reg[i];
            end
        end
    end

    // round half up to the trig fraction width and clamp to [-1, 1]
    assign x_round = ((CORDIC_W+1)'(x_reg[CORDIC_STEPS]) + RND_HALF) >>> RND_SH;
    assign y_round = ((CORDIC_W+1)'(y_reg[CORDIC_STEPS]) + RND_HALF) >>> RND_SH;

    always_comb begin
        if (x_round > ONE_WIDE) begin
            c_clamp = TRIG_ONE;
        end else if (x_round < -ONE_WIDE) begin
            c_clamp = -TRIG_ONE;
        end else begin
            c_clamp = x_round[TW-1:0];
        end
        if (y_round > ONE_WIDE) begin
            s_clamp = TRIG_ONE;
        end else if (y_round < -ONE_WIDE) begin
            s_clamp = -TRIG_ONE;
        end else begin
            s_clamp = y_round[TW-1:0];
        end
    end

    // map the residual result back into its quadrant
    always_comb begin
        case (quad_reg[CORDIC_STEPS])
            QUAD_I: begin
                cos_next = c_clamp;
                sin_next = s_clamp;
            end
            QUAD_II: begin
                cos_next = -s_clamp;
                sin_next = c_clamp;
            end
            QUAD_III: begin
                cos_next = -c_clamp;
                sin_next = -s_clamp;
            end
            default: begin
                cos_next = s_clamp;
                sin_next = -c_clamp;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sin_out   = sin_reg;
    assign cos_out   = cos_reg;

    // rounded sine and cosine never leave [-1, 1]
    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (sin_reg <= TRIG_ONE && sin_reg >= -TRIG_ONE &&
                           cos_reg <= TRIG_ONE && cos_reg >= -TRIG_ONE))
        else $error("sine or cosine out of range");

    // the angle residual has converged by the last micro-rotation
    a_cordic_converged: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[CORDIC_STEPS] |->
            (z_reg[CORDIC_STEPS] <= Z_TOL && z_reg[CORDIC_STEPS] >= -Z_TOL))
        else $error("cordic residual angle did not converge");

endmodule

// ===== sv/rrq_prep.sv =====
// rotation center and corner offsets, delayed to line up with the trig pipeline
module rrq_prep #(
    parameter int COORD_BITS = 24,
    parameter int DEPTH      = 32
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic                         op,
    input  logic signed [COORD_BITS-1:0] rect_x,
    input  logic signed [COORD_BITS-1:0] rect_y,
    input  logic        [COORD_BITS-2:0] rect_w,
    input  logic        [COORD_BITS-2:0] rect_h,
    input  logic signed [COORD_BITS-1:0] pivot_x,
    input  logic signed [COORD_BITS-1:0] pivot_y,
    output logic signed [COORD_BITS+1:0] cx2,
    output logic signed [COORD_BITS+1:0] cy2,
    output logic signed [COORD_BITS+2:0] dx0,
    output logic signed [COORD_BITS+2:0] dx1,
    output logic signed [COORD_BITS+2:0] dy0,
    output logic signed [COORD_BITS+2:0] dy2
);
    localparam int CW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 3;
    localparam int GW = 2*CW + 4*DW;

    logic signed [DW-1:0] x_e;
    logic signed [DW-1:0] y_e;
    logic signed [DW-1:0] w_e;
    logic signed [DW-1:0] h_e;
    logic signed [DW-1:0] px_e;
    logic signed [DW-1:0] py_e;
    logic signed [CW-1:0] cx2_next;
    logic signed [CW-1:0] cy2_next;
    logic signed [DW-1:0] dx0_next;
    logic signed [DW-1:0] dx1_next;
    logic signed [DW-1:0] dy0_next;
    logic signed [DW-1:0] dy2_next;
    logic [GW-1:0]        geo_next;
    logic [GW-1:0]        geo_reg [0:DEPTH-1];

    assign x_e  = DW'(rect_x);
    assign y_e  = DW'(rect_y);
    assign w_e  = signed'(DW'(rect_w));
    assign h_e  = signed'(DW'(rect_h));
    assign px_e = DW'(pivot_x);
    assign py_e = DW'(pivot_y);

    // everything doubled so that half sizes stay exact
    always_comb begin
        if (op) begin
            cx2_next = CW'(px_e <<< 1);
            cy2_next = CW'(py_e <<< 1);
            dx0_next = (x_e - px_e) <<< 1;
            dx1_next = (x_e + w_e - px_e) <<< 1;
            dy0_next = (y_e - py_e) <<< 1;
            dy2_next = (y_e + h_e - py_e) <<< 1;
        end else begin
            cx2_next = CW'((x_e <<< 1) + w_e);
            cy2_next = CW'((y_e <<< 1) + h_e);
            dx0_next = -w_e;
            dx1_next = w_e;
            dy0_next = -h_e;
            dy2_next = h_e;
        end
    end

    assign geo_next = {cx2_next, cy2_next, dx0_next, dx1_next, dy0_next, dy2_next};

    // delay line matching the sine/cosine latency
    always_ff @(posedge aclk) begin
        if (en) begin
            geo_reg[0] <= geo_next;
        end
    end

    for (genvar i = 1; i < DEPTH; i++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (en) begin
                geo_reg[i] <= geo_reg[i-1];
            end
        end
    end

    assign {cx2, cy2, dx0, dx1, dy0, dy2} = geo_reg[DEPTH-1];

endmodule

// ===== sv/rrq_combine.sv =====
// corner rotation: products, sums, then rounding and saturation
module rrq_combine #(
    parameter int COORD_BITS     = 24,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [TRIG_FRAC_BITS+1:0] sin_in,
    input  logic signed [TRIG_FRAC_BITS+1:0] cos_in,
    input  logic signed [COORD_BITS+1:0]     cx2,
    input  logic signed [COORD_BITS+1:0]     cy2,
    input  logic signed [COORD_BITS+2:0]     dx0,
    input  logic signed [COORD_BITS+2:0]     dx1,
    input  logic signed [COORD_BITS+2:0]     dy0,
    input  logic signed [COORD_BITS+2:0]     dy2,
    output logic                             out_valid,
    output logic [3:0][COORD_BITS-1:0]       corner_x,
    output logic [3:0][COORD_BITS-1:0]       corner_y
);
    localparam int CW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 3;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PW = DW + TW;
    localparam int RW = PW + 1;
    localparam int VW = RW + 1;
    localparam logic signed [VW-1:0] RND_HALF = VW'(64'sd1 <<< TRIG_FRAC_BITS);
    localparam logic signed [VW-1:0] SAT_HI   = VW'((64'sd1 <<< (COORD_BITS-1)) - 64'sd1);
    localparam logic signed [VW-1:0] SAT_LO   = VW'(-(64'sd1 <<< (COORD_BITS-1)));

    // add the scaled center, round half up, drop the doubling and saturate
    function automatic logic [COORD_BITS-1:0] finish(input logic signed [CW-1:0] center2,
                                                     input logic signed [RW-1:0] rot);
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] q;
        v = (VW'(center2) <<< TRIG_FRAC_BITS) + VW'(rot) + RND_HALF;
        q = v >>> (TRIG_FRAC_BITS + 1);
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[COORD_BITS-1:0];
    endfunction

    logic                 mul_valid_reg;
    logic signed [PW-1:0] dx0c_reg, dx1c_reg, dx0s_reg, dx1s_reg;
    logic signed [PW-1:0] dy0c_reg, dy2c_reg, dy0s_reg, dy2s_reg;
    logic signed [CW-1:0] mul_cx2_reg, mul_cy2_reg;

    logic                       sum_valid_reg;
    logic signed [3:0][RW-1:0]  rot_x_next, rot_y_next;
    logic signed [3:0][RW-1:0]  rot_x_reg, rot_y_reg;
    logic signed [CW-1:0]       sum_cx2_reg, sum_cy2_reg;

    logic                        out_valid_reg;
    logic [3:0][COORD_BITS-1:0]  corner_x_next, corner_y_next;
    logic [3:0][COORD_BITS-1:0]  corner_x_reg, corner_y_reg;

    // valid bits of the three stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= in_valid;
            sum_valid_reg <= mul_valid_reg;
            out_valid_reg <= sum_valid_reg;
        end
    end

    // stage 1: the eight distinct offset by trig products
    always_ff @(posedge aclk) begin
        if (en) begin
            dx0c_reg    <= PW'(dx0) * PW'(cos_in);
            dx1c_reg    <= PW'(dx1) * PW'(cos_in);
            dx0s_reg    <= PW'(dx0) * PW'(sin_in);
            dx1s_reg    <= PW'(dx1) * PW'(sin_in);
            dy0c_reg    <= PW'(dy0) * PW'(cos_in);
            dy2c_reg    <= PW'(dy2) * PW'(cos_in);
            dy0s_reg    <= PW'(dy0) * PW'(sin_in);
            dy2s_reg    <= PW'(dy2) * PW'(sin_in);
            mul_cx2_reg <= cx2;
            mul_cy2_reg <= cy2;
        end
    end

    // stage 2: rotated offsets, corners top-left, top-right, bottom-right, bottom-left
    always_comb begin
        rot_x_next[0] = RW'(dx0c_reg) - RW'(dy0s_reg);
        rot_y_next[0] = RW'(dx0s_reg) + RW'(dy0c_reg);
        rot_x_next[1] = RW'(dx1c_reg) - RW'(dy0s_reg);
        rot_y_next[1] = RW'(dx1s_reg) + RW'(dy0c_reg);
        rot_x_next[2] = RW'(dx1c_reg) - RW'(dy2s_reg);
        rot_y_next[2] = RW'(dx1s_reg) + RW'(dy2c_reg);
        rot_x_next[3] = RW'(dx0c_reg) - RW'(dy2s_reg);
        rot_y_next[3] = RW'(dx0s_reg) + RW'(dy2c_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_x_reg   <= rot_x_next;
            rot_y_reg   <= rot_y_next;
            sum_cx2_reg <= mul_cx2_reg;
            sum_cy2_reg <= mul_cy2_reg;
        end
    end

    // stage 3: back to coordinates
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            corner_x_next[k] = finish(sum_cx2_reg, rot_x_reg[k]);
            corner_y_next[k] = finish(sum_cy2_reg, rot_y_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            corner_x_reg <= corner_x_next;
            corner_y_reg <= corner_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign corner_x  = corner_x_reg;
    assign corner_y  = corner_y_reg;

endmodule

// ===== sv/rect_rotate_to_quad.sv =====
// rect_rotate_to_quad: rotates a rectangle's four corners about its center or a pivot
// an accepted input reaches result valid through the 30-stage cordic, its reduction and
// rounding registers and the three multiply/sum/round stages; throughput one item per
// cycle while m_tready stays high; a stalled output holds the whole pipeline; reset
// clears only the stage valid bits
module rect_rotate_to_quad #(
    parameter int COORD_BITS     = 24,
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14,
    localparam int S_FIELD_BITS  = 6*COORD_BITS - 2 + ANGLE_BITS,
    localparam int S_TDATA_W     = ((S_FIELD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W     = 8*COORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // rect_x, rect_y, rect_w, rect_h, pivot_x, pivot_y, turn_angle, zero fill
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic [0:0]           s_tuser,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);
    import rrq_pkg::*;

    localparam int OFS_Y   = COORD_BITS;
    localparam int OFS_W   = 2*COORD_BITS;
    localparam int OFS_H   = 3*COORD_BITS - 1;
    localparam int OFS_PX  = 4*COORD_BITS - 2;
    localparam int OFS_PY  = 5*COORD_BITS - 2;
    localparam int OFS_ANG = 6*COORD_BITS - 2;

    logic                             adv;
    logic signed [COORD_BITS-1:0]     rect_x, rect_y, pivot_x, pivot_y;
    logic        [COORD_BITS-2:0]     rect_w, rect_h;
    logic        [ANGLE_BITS-1:0]     turn_angle;
    logic                             trig_valid;
    logic signed [TRIG_FRAC_BITS+1:0] trig_sin, trig_cos;
    logic signed [COORD_BITS+1:0]     cx2, cy2;
    logic signed [COORD_BITS+2:0]     dx0, dx1, dy0, dy2;
    logic                             res_valid;
    logic [3:0][COORD_BITS-1:0]       corner_x, corner_y;

    // the whole pipeline moves unless a finished item is waiting
    assign adv      = !res_valid || m_tready;
    assign s_tready = adv;

    // input field unpacking
    assign rect_x     = s_tdata[0 +: COORD_BITS];
    assign rect_y     = s_tdata[OFS_Y +: COORD_BITS];
    assign rect_w     = s_tdata[OFS_W +: COORD_BITS-1];
    assign rect_h     = s_tdata[OFS_H +: COORD_BITS-1];
    assign pivot_x    = s_tdata[OFS_PX +: COORD_BITS];
    assign pivot_y    = s_tdata[OFS_PY +: COORD_BITS];
    assign turn_angle = s_tdata[OFS_ANG +: ANGLE_BITS];

    rrq_sincos #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_sincos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .angle     (turn_angle),
        .out_valid (trig_valid),
        .sin_out   (trig_sin),
        .cos_out   (trig_cos)
    );

    rrq_prep #(
        .COORD_BITS (COORD_BITS),
        .DEPTH      (SINCOS_LAT)
    ) u_prep (
        .aclk    (aclk),
        .en      (adv),
        .op      (s_tuser[0]),
        .rect_x  (rect_x),
        .rect_y  (rect_y),
        .rect_w  (rect_w),
        .rect_h  (rect_h),
        .pivot_x (pivot_x),
        .pivot_y (pivot_y),
        .cx2     (cx2),
        .cy2     (cy2),
        .dx0     (dx0),
        .dx1     (dx1),
        .dy0     (dy0),
        .dy2     (dy2)
    );

    rrq_combine #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (trig_valid),
        .sin_in    (trig_sin),
        .cos_in    (trig_cos),
        .cx2       (cx2),
        .cy2       (cy2),
        .dx0       (dx0),
        .dx1       (dx1),
        .dy0       (dy0),
        .dy2       (dy2),
        .out_valid (res_valid),
        .corner_x  (corner_x),
        .corner_y  (corner_y)
    );

    // result packing
    for (genvar k = 0; k < 4; k++) begin : g_pack
        assign m_tdata[(2*k)*COORD_BITS +: COORD_BITS]   = corner_x[k];
        assign m_tdata[(2*k+1)*COORD_BITS +: COORD_BITS] = corner_y[k];
    end

    assign m_tvalid = res_valid;

    // a waiting result stops intake in the same cycle
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

// ===== test/quad_checker.sv =====
// rotated-quad checker: predicts each item's four rotated corners and compares results
module quad_checker #(
    parameter int COORD_BITS     = 24,
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14,
    parameter int S_TDATA_W      = 160,
    parameter int M_TDATA_W      = 192
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   pending,
    output int                   quads_checked
);

    localparam int CB     = COORD_BITS;
    localparam int OFF_Y  = CB;
    localparam int OFF_W  = 2*CB;
    localparam int OFF_H  = 3*CB - 1;
    localparam int OFF_PX = 4*CB - 2;
    localparam int OFF_PY = 5*CB - 2;
    localparam int OFF_A  = 6*CB - 2;

    localparam int ROT_STEPS = 30;
    localparam longint GAIN_INV = 64'sd652032874;

    // arctangent of 2^-i in 2^-32 turn units
    localparam longint ATAN_2PI [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef logic signed [CB-1:0] coord_t;

    typedef struct packed {
        logic                  op;
        coord_t                rect_x;
        coord_t                rect_y;
        logic [CB-2:0]         rect_w;
        logic [CB-2:0]         rect_h;
        coord_t                pivot_x;
        coord_t                pivot_y;
        logic [ANGLE_BITS-1:0] turn_angle;
    } rect_item_t;

    // corner0_x at index 0 up to corner3_y at index 7, same order as m_tdata
    typedef logic [7:0][CB-1:0] quad_corners_t;

    quad_corners_t quad_expected [$];
    int err_count  = 0;
    int shown      = 0;
    int done_count = 0;

    // round a 30-fraction-bit value half up to the trig precision, clamp to +-1
    function automatic longint trig_round(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
        if (r > (longint'(1) <<< TRIG_FRAC_BITS))
            r = longint'(1) <<< TRIG_FRAC_BITS;
        if (r < -(longint'(1) <<< TRIG_FRAC_BITS))
            r = -(longint'(1) <<< TRIG_FRAC_BITS);
        return r;
    endfunction

    // quadrant reduction plus fixed-length cordic
    function automatic void sin_cos_fixed(input logic [ANGLE_BITS-1:0] ang,
                                          output longint sn, output longint cs);
        logic [31:0] a;
        logic [31:0] shifted;
        logic [31:0] resid;
        logic [1:0]  q;
        longint x, y, z, xs, ys, c, s;
        int i;
        a = 32'(ang) << (32 - ANGLE_BITS);
        shifted = a + 32'h2000_0000;
        q = shifted[31:30];
        resid = a - {q, 30'b0};
        z = longint'($signed(resid));
        x = GAIN_INV;
        y = 0;
        for (i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_2PI[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_2PI[i];
            end
        end
        c = trig_round(x);
        s = trig_round(y);
        case (rrq_pkg::quad_t'(q))
            rrq_pkg::QUAD_I: begin
                cs = c;
                sn = s;
            end
            rrq_pkg::QUAD_II: begin
                cs = -s;
                sn = c;
            end
            rrq_pkg::QUAD_III: begin
                cs = -c;
                sn = -s;
            end
            default: begin
                cs = s;
                sn = -c;
            end
        endcase
    endfunction

    // add doubled center, halve with rounding half up, saturate
    function automatic coord_t place_coord(input longint center2, input longint rot);
        longint v;
        v = (center2 <<< TRIG_FRAC_BITS) + rot;
        v = (v + (longint'(1) <<< TRIG_FRAC_BITS)) >>> (TRIG_FRAC_BITS + 1);
        if (v > (longint'(1) <<< (CB - 1)) - 1)
            v = (longint'(1) <<< (CB - 1)) - 1;
        if (v < -(longint'(1) <<< (CB - 1)))
            v = -(longint'(1) <<< (CB - 1));
        return coord_t'(v);
    endfunction

    // all coordinates doubled so half sizes stay exact
    function automatic quad_corners_t rotate_corners(input rect_item_t r);
        longint x, y, w, h, px, py, sn, cs, cx2, cy2;
        longint dx [4];
        longint dy [4];
        quad_corners_t q;
        int k;
        sin_cos_fixed(r.turn_angle, sn, cs);
        x  = longint'(r.rect_x);
        y  = longint'(r.rect_y);
        w  = longint'(r.rect_w);
        h  = longint'(r.rect_h);
        px = longint'(r.pivot_x);
        py = longint'(r.pivot_y);
        if (r.op) begin
            cx2 = 2 * px;
            cy2 = 2 * py;
            dx[0] = 2 * (x - px);
            dy[0] = 2 * (y - py);
            dx[1] = 2 * (x + w - px);
            dy[1] = dy[0];
            dx[2] = dx[1];
            dy[2] = 2 * (y + h - py);
            dx[3] = dx[0];
            dy[3] = dy[2];
        end else begin
            cx2 = 2 * x + w;
            cy2 = 2 * y + h;
            dx[0] = -w;
            dy[0] = -h;
            dx[1] = w;
            dy[1] = -h;
            dx[2] = w;
            dy[2] = h;
            dx[3] = -w;
            dy[3] = h;
        end
        for (k = 0; k < 4; k++) begin
            q[2*k]   = place_coord(cx2, dx[k] * cs - dy[k] * sn);
            q[2*k+1] = place_coord(cy2, dx[k] * sn + dy[k] * cs);
        end
        return q;
    endfunction

    function automatic rect_item_t unpack_rect(input logic [S_TDATA_W-1:0] d,
                                               input logic [0:0] u);
        rect_item_t r;
        r.op         = u[0];
        r.rect_x     = d[0 +: CB];
        r.rect_y     = d[OFF_Y +: CB];
        r.rect_w     = d[OFF_W +: CB-1];
        r.rect_h     = d[OFF_H +: CB-1];
        r.pivot_x    = d[OFF_PX +: CB];
        r.pivot_y    = d[OFF_PY +: CB];
        r.turn_angle = d[OFF_A +: ANGLE_BITS];
        return r;
    endfunction

    // predict on each accepted item, compare on each accepted result
    always @(posedge aclk) begin
        quad_corners_t want;
        quad_corners_t got;
        int f;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                quad_expected = {quad_expected,
                                 rotate_corners(unpack_rect(s_tdata, s_tuser))};
            if (m_tvalid && m_tready) begin
                got = quad_corners_t'(m_tdata);
                if (quad_expected.size() == 0) begin
                    err_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("quad_checker: unexpected result %h", m_tdata);
                    end
                end else begin
                    want = quad_expected.pop_front();
                    for (f = 0; f < 8; f++) begin
                        if (got[f] !== want[f]) begin
                            err_count++;
                            if (shown < 10) begin
                                shown++;
                                $display({"quad_checker: quad %0d corner%0d_%s",
                                          " expected %0d got %0d"},
                                         done_count, f / 2, (f % 2) ? "y" : "x",
                                         $signed(want[f]), $signed(got[f]));
                            end
                        end
                    end
                end
                done_count++;
            end
        end
        mismatches    <= err_count;
        pending       <= quad_expected.size();
        quads_checked <= done_count;
    end

endmodule

// ===== test/tb.sv =====
// testbench top: clock, reset, rectangle stimulus, output stalls and the verdict
module tb;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 192;
    localparam int RANDOM_RECTS = 1600;
    localparam int TAIL_CYCLES = rrq_pkg::SINCOS_LAT + 3 + 8;

    localparam logic [23:0] COORD_MAX = 24'h7F_FFFF;
    localparam logic [23:0] COORD_MIN = 24'h80_0000;
    localparam logic [22:0] SIZE_MAX  = 23'h7F_FFFF;

    typedef struct packed {
        logic        op;
        logic [23:0] rect_x;
        logic [23:0] rect_y;
        logic [22:0] rect_w;
        logic [22:0] rect_h;
        logic [23:0] pivot_x;
        logic [23:0] pivot_y;
        logic [15:0] turn_angle;
    } rect_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int  mismatches;
    int  pending;
    int  quads_checked;
    int  sent_center;
    int  sent_pivot;
    bit  tx_gaps;
    bit  rx_stalls;

    rect_rotate_to_quad uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    quad_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .quads_checked (quads_checked)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic rect_t make_rect(input logic op, input logic [23:0] x,
                                        input logic [23:0] y, input logic [22:0] w,
                                        input logic [22:0] h, input logic [23:0] px,
                                        input logic [23:0] py, input logic [15:0] ang);
        rect_t r;
        r.op = op;
        r.rect_x = x;
        r.rect_y = y;
        r.rect_w = w;
        r.rect_h = h;
        r.pivot_x = px;
        r.pivot_y = py;
        r.turn_angle = ang;
        return r;
    endfunction

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 24'd0;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [22:0] pick_size();
        case ($urandom_range(0, 2))
            0: return SIZE_MAX;
            1: return 23'd0;
            default: return 23'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] near_coord();
        return 24'($urandom_range(0, 2097151)) - 24'd1048576;
    endfunction

    // mostly screen-sized geometry, some full-range noise and some extremes
    function automatic rect_t random_rect();
        rect_t r;
        int kind;
        kind = $urandom_range(0, 9);
        r.op = 1'($urandom);
        if (kind < 3) begin
            r.rect_x  = 24'($urandom);
            r.rect_y  = 24'($urandom);
            r.rect_w  = 23'($urandom);
            r.rect_h  = 23'($urandom);
            r.pivot_x = 24'($urandom);
            r.pivot_y = 24'($urandom);
        end else if (kind < 9) begin
            r.rect_x  = near_coord();
            r.rect_y  = near_coord();
            r.rect_w  = 23'($urandom_range(0, 262144));
            r.rect_h  = 23'($urandom_range(0, 262144));
            r.pivot_x = near_coord();
            r.pivot_y = near_coord();
        end else begin
            r.rect_x  = pick_coord();
            r.rect_y  = pick_coord();
            r.rect_w  = pick_size();
            r.rect_h  = pick_size();
            r.pivot_x = pick_coord();
            r.pivot_y = pick_coord();
        end
        // some angles sit on or within two steps of the octant boundaries
        if ($urandom_range(0, 3) == 0)
            r.turn_angle = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 4) - 2);
        else
            r.turn_angle = 16'($urandom);
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_rect(input rect_t r);
        int gap;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = S_TDATA_W'({r.turn_angle, r.pivot_y, r.pivot_x,
                               r.rect_h, r.rect_w, r.rect_y, r.rect_x});
        s_tuser  = r.op;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (r.op)
            sent_pivot++;
        else
            sent_center++;
        @(negedge aclk);
    endtask

    // result side back-pressure
    initial begin
        int stall;
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (rx_stalls && aresetn && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 17);
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        sent_center = 0;
        sent_pivot  = 0;
        tx_gaps     = 1'b0;
        rx_stalls   = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: quadrant and octant angles, sizes, pivots and saturation
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h800, 23'h400, 24'd0, 24'd0, 16'd0));
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h800, 23'h400, 24'd0, 24'd0, 16'd16384));
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h800, 23'h400, 24'd0, 24'd0, 16'd32768));
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h800, 23'h400, 24'd0, 24'd0, 16'd49152));
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h800, 23'h400, 24'd0, 24'd0, 16'd8192));
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h800, 23'h400, 24'd0, 24'd0, 16'd8191));
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h800, 23'h400, 24'd0, 24'd0, 16'd65535));
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h800, 23'h400, 24'd0, 24'd0, 16'd57344));
        send_rect(make_rect(1'b0, 24'h1000, 24'h2000, 23'h801, 23'h3FF, 24'd0, 24'd0, 16'd1));
        send_rect(make_rect(1'b1, 24'h100, 24'h100, 23'h200, 23'h300, 24'd0, 24'd0, 16'd40960));
        // pivot fields must not matter in center mode
        send_rect(make_rect(1'b0, 24'h3000, 24'hFF_F000, 23'h1234, 23'h777, COORD_MAX,
                            COORD_MIN, 16'd24576));
        // degenerate sizes
        send_rect(make_rect(1'b0, 24'h5555, 24'hAAAA, 23'd0, 23'd0, 24'd0, 24'd0, 16'd1234));
        send_rect(make_rect(1'b1, 24'h5555, 24'hAAAA, 23'd0, 23'h900, 24'h10, 24'h20, 16'd20000));
        // saturation at both ends
        send_rect(make_rect(1'b0, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, 24'd0, 24'd0,
                            16'd0));
        send_rect(make_rect(1'b0, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, 24'd0, 24'd0,
                            16'd32768));
        send_rect(make_rect(1'b1, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, COORD_MIN,
                            COORD_MIN, 16'd16384));
        send_rect(make_rect(1'b1, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, COORD_MAX,
                            COORD_MAX, 16'd49152));
        send_rect(make_rect(1'b1, 24'hFF_FFFF, 24'hFF_FFFF, SIZE_MAX, SIZE_MAX, 24'hFF_FFFF,
                            24'hFF_FFFF, 16'hFFFF));
        send_rect(make_rect(1'b0, 24'd0, 24'd0, 23'd0, 23'd0, 24'd0, 24'd0, 16'd0));
        send_rect(make_rect(1'b1, COORD_MAX, COORD_MIN, 23'd0, SIZE_MAX, COORD_MIN,
                            COORD_MAX, 16'd8192));

        // random items, with gaps and stalls in overlapping windows
        for (n = 0; n < RANDOM_RECTS; n++) begin
            tx_gaps   = (n < 1000) && !(n >= 400 && n < 550);
            rx_stalls = (n >= 150) && (n < 1200);
            send_rect(random_rect());
        end
        s_tvalid  = 1'b0;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;

        // drain the pipeline, then let it settle
        while (pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("summary: %0d rectangles sent (%0d about center, %0d about pivot)",
                 sent_center + sent_pivot, sent_center, sent_pivot);
        $display("summary: %0d quads compared, %0d mismatching fields", quads_checked,
                 mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
